@@ src/mh_pkg.sv @@
package mh_pkg;

    localparam logic [31:0] MUR_M        = 32'h5bd1e995;
    localparam logic [31:0] DEFAULT_SEED = 32'hee6b27eb;
    localparam int unsigned MUR_R        = 24;
    localparam int unsigned FIN_S1       = 18;
    localparam int unsigned FIN_S2       = 22;
    localparam int unsigned FIN_S3       = 17;
    localparam int unsigned FIN_S4       = 19;

    // byte counts of a partial tail word
    localparam logic [2:0] CNT_ONE   = 3'd1;
    localparam logic [2:0] CNT_TWO   = 3'd2;
    localparam logic [2:0] CNT_THREE = 3'd3;

    // datapath operation issued each cycle by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,   // accept beat, k = word * M, optional state load
        OP_KEY,    // k = (k ^ k >> 24) * M
        OP_MIX,    // h = h * M ^ k on the selected half
        OP_TAIL,   // h2 = (h2 ^ masked word) * M
        OP_FIN1,
        OP_FIN2,
        OP_FIN3,
        OP_FIN4    // last cross-mix round, loads the output register
    } mh_op_t;

    typedef struct packed {
        mh_op_t op;
    } mh_cmd_t;

    typedef struct packed {
        logic in_full;     // incoming beat holds a full word
        logic in_partial;  // incoming beat holds a 1..3 byte tail
        logic in_last;     // incoming beat ends the message
        logic last_reg;    // latched last mark of the beat in work
        logic out_free;    // output register can take a result this cycle
    } mh_sts_t;

endpackage

@@ src/mh_in_if.sv @@
interface mh_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        first_item;
    logic        last_item;
    logic [30:0] message_length;

    modport source (
        output valid, data_word, byte_count, first_item, last_item, message_length,
        input  ready
    );
    modport sink (
        input  valid, data_word, byte_count, first_item, last_item, message_length,
        output ready
    );
endinterface

@@ src/mh_out_if.sv @@
interface mh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source (
        output valid, hash_value,
        input  ready
    );
    modport sink (
        input  valid, hash_value,
        output ready
    );
endinterface

@@ src/mh_ctrl.sv @@
module mh_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mh_pkg::mh_sts_t sts,
    output mh_pkg::mh_cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_KEY  = 8'b0000_0010,
        ST_MIX  = 8'b0000_0100,
        ST_TAIL = 8'b0000_1000,
        ST_FIN1 = 8'b0001_0000,
        ST_FIN2 = 8'b0010_0000,
        ST_FIN3 = 8'b0100_0000,
        ST_FIN4 = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = mh_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = mh_pkg::OP_LOAD;
                    if (sts.in_full)
                        state_next = ST_KEY;
                    else if (sts.in_partial)
                        state_next = ST_TAIL;
                    else if (sts.in_last)
                        state_next = ST_FIN1;
                end
            end
            ST_KEY:
            begin
                cmd.op     = mh_pkg::OP_KEY;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                cmd.op     = mh_pkg::OP_MIX;
                state_next = sts.last_reg ? ST_FIN1 : ST_IDLE;
            end
            ST_TAIL:
            begin
                cmd.op     = mh_pkg::OP_TAIL;
                state_next = sts.last_reg ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1:
            begin
                cmd.op     = mh_pkg::OP_FIN1;
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                cmd.op     = mh_pkg::OP_FIN2;
                state_next = ST_FIN3;
            end
            ST_FIN3:
            begin
                cmd.op     = mh_pkg::OP_FIN3;
                state_next = ST_FIN4;
            end
            ST_FIN4:
            begin
                // hold here until the output register is free
                if (sts.out_free)
                begin
                    cmd.op     = mh_pkg::OP_FIN4;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ src/mh_datapath.sv @@
module mh_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [31:0]     cfg_data,
    mh_in_if.sink           msg,
    mh_out_if.source        result,
    input  mh_pkg::mh_cmd_t cmd,
    output mh_pkg::mh_sts_t sts
);

    logic [31:0] seed_reg;
    logic [31:0] h1_reg;
    logic [31:0] h2_reg;
    logic        odd_reg;
    logic [31:0] k_reg;
    logic [31:0] word_reg;
    logic [2:0]  count_reg;
    logic        last_reg;
    logic [31:0] f1_reg;
    logic [31:0] f2_reg;
    logic [63:0] hash_reg;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic [31:0] tail_mask;
    logic [31:0] mul_a;
    logic [31:0] prod;

    assign sts.in_full    = msg.byte_count[2];
    assign sts.in_partial = !msg.byte_count[2] && (msg.byte_count != 3'd0);
    assign sts.in_last    = msg.last_item;
    assign sts.last_reg   = last_reg;
    assign sts.out_free   = !out_valid_reg || result.ready;

    assign result.valid      = out_valid_reg;
    assign result.hash_value = hash_reg;

    always_comb
    begin
        case (count_reg)
            mh_pkg::CNT_ONE:   tail_mask = 32'h0000_00ff;
            mh_pkg::CNT_TWO:   tail_mask = 32'h0000_ffff;
            mh_pkg::CNT_THREE: tail_mask = 32'h00ff_ffff;
            default:           tail_mask = 32'h0000_0000;
        endcase
    end

    // one shared multiplier by M, operand picked by the current op
    always_comb
    begin
        case (cmd.op)
            mh_pkg::OP_LOAD: mul_a = msg.data_word;
            mh_pkg::OP_KEY:  mul_a = k_reg ^ (k_reg >> mh_pkg::MUR_R);
            mh_pkg::OP_MIX:  mul_a = odd_reg ? h2_reg : h1_reg;
            mh_pkg::OP_TAIL: mul_a = h2_reg ^ (word_reg & tail_mask);
            mh_pkg::OP_FIN1: mul_a = h1_reg ^ (h2_reg >> mh_pkg::FIN_S1);
            mh_pkg::OP_FIN2: mul_a = h2_reg ^ (f1_reg >> mh_pkg::FIN_S2);
            mh_pkg::OP_FIN3: mul_a = f1_reg ^ (f2_reg >> mh_pkg::FIN_S3);
            mh_pkg::OP_FIN4: mul_a = f2_reg ^ (f1_reg >> mh_pkg::FIN_S4);
            default:         mul_a = 32'h0000_0000;
        endcase
    end

    assign prod = mul_a * mh_pkg::MUR_M;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= mh_pkg::DEFAULT_SEED;
        else if (cfg_we)
            seed_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_reg  <= 32'h0000_0000;
            h2_reg  <= 32'h0000_0000;
            odd_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                mh_pkg::OP_LOAD:
                begin
                    if (msg.first_item)
                    begin
                        h1_reg  <= seed_reg ^ {1'b0, msg.message_length};
                        h2_reg  <= 32'h0000_0000;
                        odd_reg <= 1'b0;
                    end
                end
                mh_pkg::OP_MIX:
                begin
                    if (odd_reg)
                        h2_reg <= prod ^ k_reg;
                    else
                        h1_reg <= prod ^ k_reg;
                    odd_reg <= !odd_reg;
                end
                mh_pkg::OP_TAIL:
                begin
                    h2_reg <= prod;
                end
                default:
                begin
                end
            endcase
        end
    end

    // beat fields and working values
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            mh_pkg::OP_LOAD:
            begin
                k_reg     <= prod;
                word_reg  <= msg.data_word;
                count_reg <= msg.byte_count;
                last_reg  <= msg.last_item;
            end
            mh_pkg::OP_KEY:  k_reg    <= prod;
            mh_pkg::OP_FIN1: f1_reg   <= prod;
            mh_pkg::OP_FIN2: f2_reg   <= prod;
            mh_pkg::OP_FIN3: f1_reg   <= prod;
            mh_pkg::OP_FIN4: hash_reg <= {f1_reg, prod};
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (cmd.op == mh_pkg::OP_FIN4)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

endmodule

@@ src/murmur_hash_64b.sv @@
// MurmurHash64B engine, one message word per input beat.
// msg (sink): data_word little-endian, byte_count 4 for full words, 1..3 for
//   the tail, 0 only for an empty message. first_item loads h1 = seed ^
//   message_length and h2 = 0; last_item starts the cross-mix and a result.
// result (source): one 64-bit hash_value beat per message, h1 high, h2 low.
// cfg: cfg_we/cfg_data write the seed; write only while the block is idle.
// Steps, all through one shared 32x32 multiplier by M:
//   full word: load (k*M), key (k*M), mix (h*M); tail word: load, then (h2^tail)*M;
//   empty item: load only; finalization adds the cross-mix rounds FIN1..FIN4.
//   A last full word passes KEY, MIX and FIN1..FIN4 before result.valid is set.
// msg.ready is high only while the controller is idle; a result held in the
// output register does not block new beats, but the last finalize round
// waits for the output register, so a stalled receiver stalls only the next
// message's end.
// Reset: h1, h2 and the word parity clear, the seed returns to 0xee6b27eb,
// and no result is pending.
module murmur_hash_64b (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    mh_in_if.sink       msg,
    mh_out_if.source    result
);

    mh_pkg::mh_cmd_t cmd;
    mh_pkg::mh_sts_t sts;

    // sequencing of multiply steps
    mh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (msg.valid),
        .in_ready (msg.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // hash state, shared multiplier and output register
    mh_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .msg      (msg),
        .result   (result),
        .cmd      (cmd),
        .sts      (sts)
    );

    // accepted beat always starts with the load step
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        (msg.valid && msg.ready) |-> (cmd.op == mh_pkg::OP_LOAD))
        else $error("accepted beat without load step");

    // an empty last item goes straight to finalization
    a_empty_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (msg.valid && msg.ready && msg.last_item && (msg.byte_count == 3'd0))
        |=> (cmd.op == mh_pkg::OP_FIN1))
        else $error("empty last item did not finalize");

    // a full word not ending the message frees the input once its key and mix steps are done
    a_full_word_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (msg.valid && msg.ready && msg.byte_count[2] && !msg.last_item)
        |=> ##2 msg.ready)
        else $error("full word took longer than three cycles");

    // the last cross-mix round always lands in the output register
    a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == mh_pkg::OP_FIN4) |=> result.valid)
        else $error("finalized hash not presented");

endmodule

@@ tb/tb_murmur_hash_64b.sv @@
module tb_murmur_hash_64b;

    // byte_count values that are not tail codes in the package
    localparam logic [2:0] CNT_NONE = 3'd0;
    localparam logic [2:0] CNT_FULL = 3'd4;

    // Cycles to let the engine settle once the last hash is in. A full word
    // plus four cross-mix rounds and the output stage fit well inside this.
    localparam int SETTLE      = 16;
    localparam int PHASE_BEATS = 85;
    localparam int NUM_PHASES  = 6;
    localparam int SHOW_MAX    = 10;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  cnt;
        logic        first;
        logic        last;
        logic [30:0] len;
    } beat_t;

    // One row of the directed table. seed_set writes the seed (after a
    // drain) before the beat goes out; known means the hash is typed in.
    typedef struct packed {
        beat_t       b;
        logic        seed_set;
        logic [31:0] seed;
        logic        known;
        logic [63:0] hash;
    } row_t;

    localparam int DIR_ROWS = 21;
    localparam row_t DIRECTED [DIR_ROWS] = '{
        // fresh out of reset: zero state, empty beat ignores the word -> 0
        '{'{32'hffffffff, 3'd0, 1'b0, 1'b1, 31'h7fffffff}, 1'b0, 32'h0, 1'b1, 64'h0},
        // no start mark: continue from the zero state
        '{'{32'h00000000, 3'd4, 1'b0, 1'b0, 31'h00000000}, 1'b0, 32'h0, 1'b0, 64'h0},
        // count 5 acts as a full word
        '{'{32'hffffffff, 3'd5, 1'b0, 1'b1, 31'h00000000}, 1'b0, 32'h0, 1'b0, 64'h0},
        // max length, then all-zero / all-one words, 1-byte tail with junk above
        '{'{32'h00000000, 3'd4, 1'b1, 1'b0, 31'h7fffffff}, 1'b0, 32'h0, 1'b0, 64'h0},
        '{'{32'hffffffff, 3'd4, 1'b0, 1'b0, 31'h00000000}, 1'b0, 32'h0, 1'b0, 64'h0},
        '{'{32'hffffffff, 3'd1, 1'b0, 1'b1, 31'h00000000}, 1'b0, 32'h0, 1'b0, 64'h0},
        // single-beat tails of three and two bytes
        '{'{32'hdeadbeef, 3'd3, 1'b1, 1'b1, 31'd3}, 1'b0, 32'h0, 1'b0, 64'h0},
        '{'{32'h1234ffff, 3'd2, 1'b1, 1'b1, 31'd2}, 1'b0, 32'h0, 1'b0, 64'h0},
        // empty message under the reset seed
        '{'{32'h00000000, 3'd0, 1'b1, 1'b1, 31'd0}, 1'b0, 32'h0, 1'b0, 64'h0},
        // count 6 full, tail in mid-stream, full, count 7 full to end
        '{'{32'h01234567, 3'd6, 1'b1, 1'b0, 31'd10}, 1'b0, 32'h0, 1'b0, 64'h0},
        '{'{32'h89abcdef, 3'd2, 1'b0, 1'b0, 31'd0}, 1'b0, 32'h0, 1'b0, 64'h0},
        '{'{32'hfedcba98, 3'd4, 1'b0, 1'b0, 31'd0}, 1'b0, 32'h0, 1'b0, 64'h0},
        '{'{32'h76543210, 3'd7, 1'b0, 1'b1, 31'd0}, 1'b0, 32'h0, 1'b0, 64'h0},
        // length field disagrees with the bytes sent
        '{'{32'h00000041, 3'd1, 1'b1, 1'b1, 31'd100}, 1'b0, 32'h0, 1'b0, 64'h0},
        // seed 0 and length 0: h1 = h2 = 0, cross-mix keeps zero
        '{'{32'haaaaaaaa, 3'd0, 1'b1, 1'b1, 31'd0}, 1'b1, 32'h00000000, 1'b1, 64'h0},
        // all-ones seed
        '{'{32'h55555555, 3'd4, 1'b1, 1'b1, 31'd4}, 1'b1, 32'hffffffff, 1'b0, 64'h0},
        // tail first, then a full word to the end
        '{'{32'h80000000, 3'd3, 1'b1, 1'b0, 31'd7}, 1'b0, 32'h0, 1'b0, 64'h0},
        '{'{32'h7fffffff, 3'd4, 1'b0, 1'b1, 31'd0}, 1'b0, 32'h0, 1'b0, 64'h0},
        // two-word message under another seed
        '{'{32'hcafef00d, 3'd4, 1'b1, 1'b0, 31'd8}, 1'b1, 32'h9747b28c, 1'b0, 64'h0},
        '{'{32'h0badc0de, 3'd4, 1'b0, 1'b1, 31'd0}, 1'b0, 32'h0, 1'b0, 64'h0},
        // after the last beat the pre-mix state stays: same hash again
        '{'{32'h00000000, 3'd0, 1'b0, 1'b1, 31'd0}, 1'b0, 32'h0, 1'b0, 64'h0}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;

    mh_in_if  msg_bus ();
    mh_out_if res_bus ();

    murmur_hash_64b DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .msg      (msg_bus),
        .result   (res_bus)
    );

    // software copy of the engine state
    logic [31:0] cur_seed;
    logic [31:0] acc_hi;
    logic [31:0] acc_lo;
    logic        acc_odd;

    logic [63:0] hash_expected [$];
    logic [63:0] hash_want;

    int  n_fail;
    int  n_shown;
    int  beats_sent;
    bit  calm_tx;
    bit  calm_rx;
    int  rx_gap;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Four-round cross-mix; h1 goes to the upper half.
    function automatic logic [63:0] cross_mix(input logic [31:0] a, input logic [31:0] b);
        a = (a ^ (b >> mh_pkg::FIN_S1)) * mh_pkg::MUR_M;
        b = (b ^ (a >> mh_pkg::FIN_S2)) * mh_pkg::MUR_M;
        a = (a ^ (b >> mh_pkg::FIN_S3)) * mh_pkg::MUR_M;
        b = (b ^ (a >> mh_pkg::FIN_S4)) * mh_pkg::MUR_M;
        return {a, b};
    endfunction

    // Apply one accepted beat to the state; flags and returns a hash on the
    // last mark. The finalized values are not written back.
    task automatic absorb_beat(input beat_t b, output bit has_hash, output logic [63:0] hv);
        logic [31:0] k;
        logic [31:0] mask;
        if (b.first)
        begin
            acc_hi  = cur_seed ^ {1'b0, b.len};
            acc_lo  = 32'h0;
            acc_odd = 1'b0;
        end
        if (b.cnt >= CNT_FULL)
        begin
            k = b.word * mh_pkg::MUR_M;
            k = k ^ (k >> mh_pkg::MUR_R);
            k = k * mh_pkg::MUR_M;
            if (!acc_odd)
                acc_hi = (acc_hi * mh_pkg::MUR_M) ^ k;
            else
                acc_lo = (acc_lo * mh_pkg::MUR_M) ^ k;
            acc_odd = ~acc_odd;
        end
        else if (b.cnt != CNT_NONE)
        begin
            // tail: bytes above the count are dropped
            case (b.cnt)
                mh_pkg::CNT_ONE: mask = 32'h000000ff;
                mh_pkg::CNT_TWO: mask = 32'h0000ffff;
                default:         mask = 32'h00ffffff;
            endcase
            acc_lo = (acc_lo ^ (b.word & mask)) * mh_pkg::MUR_M;
        end
        has_hash = b.last;
        hv       = b.last ? cross_mix(acc_hi, acc_lo) : 64'h0;
    endtask

    // Idle cycles before the next beat; a side flips in and out of a
    // no-idle stretch now and then.
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 15) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    // Drive one beat, hold it until accepted, then predict. Called at a
    // rising edge; returns at the accepting edge with valid still high.
    task automatic send_beat(input beat_t b, input bit known, input logic [63:0] typed);
        int          gap;
        bit          has_hash;
        logic [63:0] hv;
        gap = draw_gap(calm_tx);
        if (gap > 0)
        begin
            msg_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_bus.valid          <= 1'b1;
        msg_bus.data_word      <= b.word;
        msg_bus.byte_count     <= b.cnt;
        msg_bus.first_item     <= b.first;
        msg_bus.last_item      <= b.last;
        msg_bus.message_length <= b.len;
        do
            @(posedge clk);
        while (!(msg_bus.valid && msg_bus.ready));
        absorb_beat(b, has_hash, hv);
        if (has_hash)
            hash_expected.push_back(known ? typed : hv);
        beats_sent++;
    endtask

    // Stop sending, wait for every pending hash, then let the engine settle.
    task automatic quiesce();
        msg_bus.valid <= 1'b0;
        while (hash_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Seed write; only called right after quiesce.
    task automatic set_seed(input logic [31:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_seed  = v;
    endtask

    // One message of nbytes bytes, split into little-endian words. Drop
    // flags break it by leaving out the start or the end mark.
    task automatic send_message(input int unsigned nbytes, input logic [30:0] len,
                                input bit drop_first, input bit drop_last);
        int unsigned nw;
        int unsigned i;
        beat_t       b;
        nw = (nbytes == 0) ? 1 : (nbytes + 3) / 4;
        for (i = 0; i < nw; i++)
        begin
            b.word = $urandom;
            if (nbytes == 0)
                b.cnt = CNT_NONE;
            else if (i < nw - 1 || nbytes % 4 == 0)
                b.cnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : CNT_FULL;
            else
                b.cnt = 3'(nbytes % 4);
            b.first = (i == 0) && !drop_first;
            b.last  = (i == nw - 1) && !drop_last;
            // length is only read with the start mark; junk elsewhere
            b.len   = (i == 0) ? len : 31'($urandom);
            send_beat(b, 1'b0, 64'h0);
        end
    endtask

    // Result checker: every accepted hash beat against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (hash_expected.size() == 0)
            begin
                n_fail++;
                if (n_shown < SHOW_MAX)
                begin
                    n_shown++;
                    $display("unexpected hash beat: got %h", res_bus.hash_value);
                end
            end
            else
            begin
                hash_want = hash_expected.pop_front();
                if (res_bus.hash_value !== hash_want)
                begin
                    n_fail++;
                    if (n_shown < SHOW_MAX)
                    begin
                        n_shown++;
                        $display("hash mismatch: expected %h, got %h",
                                 hash_want, res_bus.hash_value);
                    end
                end
            end
        end
    end

    // Receiver: random stall before each result, then ready until a beat.
    initial
    begin
        res_bus.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            rx_gap = draw_gap(calm_rx);
            if (rx_gap > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (rx_gap) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(res_bus.valid && res_bus.ready));
        end
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("murmur_hash_64b regression: fail");
        $finish;
    end

    // Sender: reset, directed table, then random phases.
    initial
    begin
        int          r;
        int          p;
        int unsigned nbytes;
        logic [30:0] len;
        logic [31:0] phase_seed;

        n_fail     = 0;
        n_shown    = 0;
        beats_sent = 0;
        calm_tx    = 1'b0;
        calm_rx    = 1'b0;
        cur_seed   = mh_pkg::DEFAULT_SEED;
        acc_hi     = 32'h0;
        acc_lo     = 32'h0;
        acc_odd    = 1'b0;

        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_data               <= 32'h0;
        msg_bus.valid          <= 1'b0;
        msg_bus.data_word      <= 32'h0;
        msg_bus.byte_count     <= CNT_NONE;
        msg_bus.first_item     <= 1'b0;
        msg_bus.last_item      <= 1'b0;
        msg_bus.message_length <= 31'h0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (r = 0; r < DIR_ROWS; r++)
        begin
            if (DIRECTED[r].seed_set)
            begin
                quiesce();
                set_seed(DIRECTED[r].seed);
            end
            send_beat(DIRECTED[r].b, DIRECTED[r].known, DIRECTED[r].hash);
        end

        // random phases: extremes of the seed first, then random seeds
        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       phase_seed = 32'h00000000;
                1:       phase_seed = 32'hffffffff;
                default: phase_seed = $urandom;
            endcase
            quiesce();
            set_seed(phase_seed);
            while (beats_sent < DIR_ROWS + (p + 1) * PHASE_BEATS)
            begin
                r = $urandom_range(0, 15);
                nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                                     : $urandom_range(0, 24);
                len = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'(nbytes);
                if (r < 2)
                begin
                    // stray beat, any count and marks
                    send_beat('{$urandom, 3'($urandom_range(0, 7)), 1'($urandom),
                                1'($urandom), 31'($urandom)}, 1'b0, 64'h0);
                end
                else if (r == 2)
                    send_message(nbytes, len, 1'($urandom), 1'($urandom));
                else
                    send_message(nbytes, len, 1'b0, 1'b0);
            end
        end

        quiesce();
        if (n_fail == 0)
            $display("murmur_hash_64b regression: pass");
        else
            $display("murmur_hash_64b regression: fail");
        $finish;
    end

endmodule
